// File: rtl/cspmv_pkg.sv
package cspmv_pkg;

	// Fixed field widths of the item channels.
	localparam int INDEX_BITS = 12;
	localparam int ACC_BITS   = 56;

	// Action codes carried by an input item.
	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_NONZERO = 2'd1,
		ACT_EMPTY   = 2'd2
	} action_t;

	// Control word travelling with an item through the pipeline.
	typedef struct packed {
		logic nonzero;
		logic empty;
		logic last;
		logic in_range;
	} ctl_t;

	// Row result handed from the accumulator stage to the output register.
	typedef struct packed {
		logic                       valid;
		logic signed [ACC_BITS-1:0] sum_re;
		logic signed [ACC_BITS-1:0] sum_im;
		logic                       saturated;
	} res_t;

endpackage

// File: rtl/cspmv_in_if.sv
interface cspmv_in_if #(
	parameter int VALUE_BITS = 24
);
	logic                                    valid;
	logic                                    ready;
	logic [1:0]                              action;
	logic [cspmv_pkg::INDEX_BITS-1:0]        index;
	logic signed [VALUE_BITS-1:0]            value_re;
	logic signed [VALUE_BITS-1:0]            value_im;
	logic                                    last_in_row;

	modport source (output valid, action, index, value_re, value_im, last_in_row, input ready);
	modport sink (input valid, action, index, value_re, value_im, last_in_row, output ready);
endinterface

// File: rtl/cspmv_out_if.sv
interface cspmv_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [cspmv_pkg::ACC_BITS-1:0] sum_re;
	logic signed [cspmv_pkg::ACC_BITS-1:0] sum_im;
	logic                                  saturated;

	modport source (output valid, sum_re, sum_im, saturated, input ready);
	modport sink (input valid, sum_re, sum_im, saturated, output ready);
endinterface

// File: rtl/csr_complex_spmv.sv
// Complex sparse matrix (compressed rows) times dense complex vector, fixed point.
// Load items write vector entries into an on-chip store of VECTOR_DEPTH entries;
// nonzero items then stream in row order and each is multiplied by the stored
// entry at its column and added into 56-bit saturating accumulators, the row sum
// (24 fraction bits for Q12.12 inputs) leaving on the item marked last in row.
// An empty-row item yields zero. One item is taken every cycle while the output
// is not stalled; a result passes, in order, the registered read of the vector
// store (loaded by the edge that takes its item), the four registered partial
// products and the output register, which takes the accumulate; all of them
// hold while the output is stalled. A load is written to the store in the
// cycle it is taken, so a nonzero in the very next item already sees it. Entries
// never loaded read as undefined values.
module csr_complex_spmv #(
	parameter int VECTOR_DEPTH = 4096,
	parameter int VALUE_BITS   = 24
) (
	input logic           clk,
	input logic           arst_n,
	cspmv_in_if.sink      item_in,
	cspmv_out_if.source   sum_out
);

	localparam int ADDR_W = $clog2(VECTOR_DEPTH);
	localparam int IDX_W  = cspmv_pkg::INDEX_BITS;
	localparam int EXT_W  = ADDR_W > IDX_W ? ADDR_W : IDX_W;

	logic                          adv;
	logic                          fire;
	logic                          in_range;
	logic [EXT_W-1:0]              index_ext;
	logic [ADDR_W-1:0]             addr;
	cspmv_pkg::ctl_t               ctl_s0;
	cspmv_pkg::ctl_t               ctl_s1;
	logic signed [VALUE_BITS-1:0]  a_re_s1;
	logic signed [VALUE_BITS-1:0]  a_im_s1;
	logic [2*VALUE_BITS-1:0]       rd_data;
	cspmv_pkg::res_t               res;
	logic                          out_valid_q;
	logic signed [cspmv_pkg::ACC_BITS-1:0] sum_re_q;
	logic signed [cspmv_pkg::ACC_BITS-1:0] sum_im_q;
	logic                          saturated_q;

	// The whole pipeline moves when the output register is free or being emptied.
	assign adv           = !out_valid_q || sum_out.ready;
	assign item_in.ready = adv;
	assign fire          = item_in.valid && adv;

	// Decode of the incoming item.
	assign index_ext = EXT_W'(item_in.index);
	assign addr      = index_ext[ADDR_W-1:0];
	assign in_range  = 32'(item_in.index) < VECTOR_DEPTH;

	always_comb begin
		ctl_s0          = '0;
		ctl_s0.in_range = in_range;
		ctl_s0.last     = item_in.last_in_row;
		unique case (item_in.action)
			cspmv_pkg::ACT_NONZERO: ctl_s0.nonzero = fire;
			cspmv_pkg::ACT_EMPTY:   ctl_s0.empty   = fire;
			default:                ctl_s0.nonzero = 1'b0;
		endcase
	end

	cspmv_vstore #(
		.DEPTH (VECTOR_DEPTH),
		.WIDTH (2 * VALUE_BITS)
	) u_vstore (
		.clk     (clk),
		.wr_en   (fire && in_range && item_in.action == cspmv_pkg::ACT_LOAD),
		.wr_addr (addr),
		.wr_data ({item_in.value_re, item_in.value_im}),
		.rd_en   (adv),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	// Stage 1: item control and matrix value, aligned with the store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_re_s1 <= item_in.value_re;
			a_im_s1 <= item_in.value_im;
		end
	end

	cspmv_cmac #(
		.VALUE_BITS (VALUE_BITS)
	) u_cmac (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_s1  (ctl_s1),
		.a_re_s1 (a_re_s1),
		.a_im_s1 (a_im_s1),
		.x_re_s1 (rd_data[2*VALUE_BITS-1:VALUE_BITS]),
		.x_im_s1 (rd_data[VALUE_BITS-1:0]),
		.res     (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_re_q    <= res.sum_re;
			sum_im_q    <= res.sum_im;
			saturated_q <= res.saturated;
		end
	end

	assign sum_out.valid     = out_valid_q;
	assign sum_out.sum_re    = sum_re_q;
	assign sum_out.sum_im    = sum_im_q;
	assign sum_out.saturated = saturated_q;

endmodule

// File: rtl/cspmv_vstore.sv
// Vector store: one write port and one registered read port.
module cspmv_vstore #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds while the pipeline is stalled.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/cspmv_cmac.sv
// Complex multiply stage followed by the saturating accumulator stage.
module cspmv_cmac #(
	parameter int VALUE_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  cspmv_pkg::ctl_t              ctl_s1,
	input  logic signed [VALUE_BITS-1:0] a_re_s1,
	input  logic signed [VALUE_BITS-1:0] a_im_s1,
	input  logic signed [VALUE_BITS-1:0] x_re_s1,
	input  logic signed [VALUE_BITS-1:0] x_im_s1,
	output cspmv_pkg::res_t              res
);

	localparam int ACC_W  = cspmv_pkg::ACC_BITS;
	localparam int PROD_W = 2 * VALUE_BITS;
	localparam int TERM_W = PROD_W + 1;
	localparam int SUM_W  = (TERM_W > ACC_W ? TERM_W : ACC_W) + 1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	cspmv_pkg::ctl_t             ctl_s2;
	logic signed [VALUE_BITS-1:0] xr;
	logic signed [VALUE_BITS-1:0] xi;
	logic signed [PROD_W-1:0]     p_rr_s2;
	logic signed [PROD_W-1:0]     p_ii_s2;
	logic signed [PROD_W-1:0]     p_ri_s2;
	logic signed [PROD_W-1:0]     p_ir_s2;
	logic signed [ACC_W-1:0]      acc_re_q;
	logic signed [ACC_W-1:0]      acc_im_q;
	logic                         ovf_q;
	logic signed [TERM_W-1:0]     term_re;
	logic signed [TERM_W-1:0]     term_im;
	logic signed [SUM_W-1:0]      sum_re;
	logic signed [SUM_W-1:0]      sum_im;
	logic                         ovf_re;
	logic                         ovf_im;
	logic signed [ACC_W-1:0]      next_re;
	logic signed [ACC_W-1:0]      next_im;

	// True when the exact sum does not fit the accumulator range.
	function automatic logic out_of_range(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-ACC_W:0] top;
		top = s[SUM_W-1:ACC_W-1];
		return !((&top) || !(|top));
	endfunction

	// Clamp an exact sum to the accumulator range.
	function automatic logic signed [ACC_W-1:0] clamp(input logic signed [SUM_W-1:0] s);
		if (!out_of_range(s)) begin
			return s[ACC_W-1:0];
		end
		return s[SUM_W-1] ? ACC_MIN : ACC_MAX;
	endfunction

	// A column beyond the store reads as zero.
	assign xr = ctl_s1.in_range ? x_re_s1 : '0;
	assign xi = ctl_s1.in_range ? x_im_s1 : '0;

	// Stage 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// The four partial products, registered.
	always_ff @(posedge clk) begin
		if (adv) begin
			p_rr_s2 <= a_re_s1 * xr;
			p_ii_s2 <= a_im_s1 * xi;
			p_ri_s2 <= a_re_s1 * xi;
			p_ir_s2 <= a_im_s1 * xr;
		end
	end

	// Exact complex term added to the accumulators, then clamped.
	always_comb begin
		term_re = TERM_W'(p_rr_s2) - TERM_W'(p_ii_s2);
		term_im = TERM_W'(p_ri_s2) + TERM_W'(p_ir_s2);
		sum_re  = SUM_W'(acc_re_q) + SUM_W'(term_re);
		sum_im  = SUM_W'(acc_im_q) + SUM_W'(term_im);
		ovf_re  = out_of_range(sum_re);
		ovf_im  = out_of_range(sum_im);
		next_re = clamp(sum_re);
		next_im = clamp(sum_im);
	end

	// Accumulators: cleared when a row closes, untouched by empty rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
			ovf_q    <= 1'b0;
		end else if (adv && ctl_s2.nonzero) begin
			if (ctl_s2.last) begin
				acc_re_q <= '0;
				acc_im_q <= '0;
				ovf_q    <= 1'b0;
			end else begin
				acc_re_q <= next_re;
				acc_im_q <= next_im;
				ovf_q    <= ovf_q | ovf_re | ovf_im;
			end
		end
	end

	// Row result: the closing sum, or zero for an empty row.
	always_comb begin
		res.valid     = ctl_s2.empty || (ctl_s2.nonzero && ctl_s2.last);
		res.sum_re    = ctl_s2.nonzero ? next_re : '0;
		res.sum_im    = ctl_s2.nonzero ? next_im : '0;
		res.saturated = ctl_s2.nonzero && (ovf_q || ovf_re || ovf_im);
	end

endmodule

// File: bench/cspmv_sum_checker.sv
`timescale 1ns / 1ps

// Watches both item channels of the complex sparse matrix-vector block,
// keeps its own copy of the vector store and the row accumulators, and
// compares every row sum that leaves the block with the sum it predicts.
module cspmv_sum_checker #(
	parameter int VECTOR_DEPTH = 4096,
	parameter int VALUE_BITS   = 24
) (
	input  logic clk,
	input  logic arst_n,
	cspmv_in_if  item_in,
	cspmv_out_if sum_out,
	output int   fail_count,
	output int   outstanding,
	output int   rows_checked,
	output int   rows_saturated
);

	localparam int     ACC_BITS = cspmv_pkg::ACC_BITS;
	localparam longint SUM_MAX  = (64'sd1 <<< (ACC_BITS - 1)) - 1;
	localparam longint SUM_MIN  = -SUM_MAX - 1;

	typedef struct packed {
		logic signed [ACC_BITS-1:0] sum_re;
		logic signed [ACC_BITS-1:0] sum_im;
		logic                       saturated;
	} row_sum_t;

	typedef struct packed {
		logic                       clipped;
		logic signed [ACC_BITS-1:0] sum;
	} clamp_t;

	logic signed [VALUE_BITS-1:0] entry_re [VECTOR_DEPTH];
	logic signed [VALUE_BITS-1:0] entry_im [VECTOR_DEPTH];
	logic signed [ACC_BITS-1:0]   row_re;
	logic signed [ACC_BITS-1:0]   row_im;
	logic                         row_clipped;
	row_sum_t                     expected_rows [$];
	int                           errors;
	int                           checked;
	int                           clipped_rows;

	// Adds an exact product term to an accumulator and clamps the result to
	// the accumulator range, flagging whether the clamp took effect.
	function automatic clamp_t accumulate(input logic signed [ACC_BITS-1:0] acc,
			input longint term);
		longint wide;
		clamp_t r;
		wide = longint'(acc) + term;
		r.clipped = 1'b1;
		if (wide > SUM_MAX) begin
			r.sum = ACC_BITS'(SUM_MAX);
		end else if (wide < SUM_MIN) begin
			r.sum = ACC_BITS'(SUM_MIN);
		end else begin
			r.sum = ACC_BITS'(wide);
			r.clipped = 1'b0;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input longint want_v, input longint got_v);
		if (want_v != got_v) begin
			errors++;
			$error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : model
		row_sum_t want;
		clamp_t   step_re;
		clamp_t   step_im;
		longint   a_re;
		longint   a_im;
		longint   x_re;
		longint   x_im;
		if (!arst_n) begin
			row_re = '0;
			row_im = '0;
			row_clipped = 1'b0;
			expected_rows.delete();
			errors = 0;
			checked = 0;
			clipped_rows = 0;
			fail_count <= 0;
			outstanding <= 0;
			rows_checked <= 0;
			rows_saturated <= 0;
		end else begin
			// A row sum leaving the block is matched against the oldest prediction.
			if (sum_out.valid && sum_out.ready) begin
				if (expected_rows.size() == 0) begin
					errors++;
					$error("row sum with no item to account for it: re %0d, im %0d",
						sum_out.sum_re, sum_out.sum_im);
				end else begin
					want = expected_rows.pop_front();
					check_field("sum_re", want.sum_re, sum_out.sum_re);
					check_field("sum_im", want.sum_im, sum_out.sum_im);
					check_field("saturated", want.saturated, sum_out.saturated);
					checked++;
					if (want.saturated)
						clipped_rows++;
				end
			end

			// Each accepted item advances the model of the store and accumulators.
			if (item_in.valid && item_in.ready) begin
				case (item_in.action)
					cspmv_pkg::ACT_LOAD: begin
						if (item_in.index < VECTOR_DEPTH) begin
							entry_re[item_in.index] = item_in.value_re;
							entry_im[item_in.index] = item_in.value_im;
						end
					end
					cspmv_pkg::ACT_EMPTY: begin
						want = '0;
						expected_rows.push_back(want);
					end
					cspmv_pkg::ACT_NONZERO: begin
						x_re = 0;
						x_im = 0;
						if (item_in.index < VECTOR_DEPTH) begin
							x_re = longint'(entry_re[item_in.index]);
							x_im = longint'(entry_im[item_in.index]);
						end
						a_re = longint'(item_in.value_re);
						a_im = longint'(item_in.value_im);
						step_re = accumulate(row_re, a_re * x_re - a_im * x_im);
						step_im = accumulate(row_im, a_re * x_im + a_im * x_re);
						row_re = step_re.sum;
						row_im = step_im.sum;
						row_clipped = row_clipped | step_re.clipped | step_im.clipped;
						if (item_in.last_in_row) begin
							want.sum_re = row_re;
							want.sum_im = row_im;
							want.saturated = row_clipped;
							expected_rows.push_back(want);
							row_re = '0;
							row_im = '0;
							row_clipped = 1'b0;
						end
					end
					default: begin
						// Unknown actions leave the block untouched.
					end
				endcase
			end

			fail_count <= errors;
			outstanding <= expected_rows.size();
			rows_checked <= checked;
			rows_saturated <= clipped_rows;
		end
	end

endmodule

// File: bench/csr_complex_spmv_test.sv
`timescale 1ns / 1ps

// Drives the complex sparse matrix-vector block with vector loads, row
// streams and empty rows under varying back-pressure, and reports the verdict
// from the checker's failure count and its count of rows still outstanding.
module csr_complex_spmv_test;

	localparam int VECTOR_DEPTH = 4096;
	localparam int VALUE_BITS   = 24;
	localparam int INDEX_BITS   = cspmv_pkg::INDEX_BITS;
	localparam int PHASE_ITEMS  = 150;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [1:0]                   ACT_UNUSED = 2'd3;
	localparam logic signed [VALUE_BITS-1:0] VAL_MAX    = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS-1:0] VAL_MIN    = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [INDEX_BITS-1:0]        INDEX_TOP  = '1;

	logic clk;
	logic arst_n;
	int   gap_pct;
	int   stall_pct;
	int   cycles = 0;
	int   work_items = 0;
	int   n_loads = 0;
	int   n_nonzeros = 0;
	int   n_empty = 0;
	int   n_ignored = 0;
	int   fail_count;
	int   outstanding;
	int   rows_checked;
	int   rows_saturated;
	bit   loaded [VECTOR_DEPTH];
	int   loaded_cols [$];

	cspmv_in_if #(.VALUE_BITS(VALUE_BITS)) item_if ();
	cspmv_out_if sum_if ();

	csr_complex_spmv #(
		.VECTOR_DEPTH(VECTOR_DEPTH),
		.VALUE_BITS  (VALUE_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item_in(item_if),
		.sum_out(sum_if)
	);

	cspmv_sum_checker #(
		.VECTOR_DEPTH(VECTOR_DEPTH),
		.VALUE_BITS  (VALUE_BITS)
	) u_sum_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_in       (item_if),
		.sum_out       (sum_if),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.rows_checked  (rows_checked),
		.rows_saturated(rows_saturated)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Receiver side: ready is withheld at random during the stalling phases.
	initial begin
		sum_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			sum_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Cycle limit for the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Full-range values, with the extremes and small values made frequent.
	function automatic logic signed [VALUE_BITS-1:0] pick_value();
		case ($urandom_range(9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return '1;
			4: return VALUE_BITS'(1);
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	// Only columns whose vector entry has been loaded are ever read.
	function automatic logic [INDEX_BITS-1:0] pick_column();
		return INDEX_BITS'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
	endfunction

	// Presents one item after a random gap and holds it until it is taken.
	task automatic send_item(input logic [1:0] act, input logic [INDEX_BITS-1:0] idx,
			input logic signed [VALUE_BITS-1:0] re, input logic signed [VALUE_BITS-1:0] im,
			input logic last);
		while ($urandom_range(99) < gap_pct) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.action <= act;
		item_if.index <= idx;
		item_if.value_re <= re;
		item_if.value_im <= im;
		item_if.last_in_row <= last;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		case (act)
			cspmv_pkg::ACT_LOAD: begin
				n_loads++;
				if (!loaded[idx]) begin
					loaded[idx] = 1'b1;
					loaded_cols.push_back(idx);
				end
			end
			cspmv_pkg::ACT_NONZERO: n_nonzeros++;
			cspmv_pkg::ACT_EMPTY:   n_empty++;
			default:                n_ignored++;
		endcase
		if (act != ACT_UNUSED)
			work_items++;
	endtask

	task automatic random_load();
		send_item(cspmv_pkg::ACT_LOAD, INDEX_BITS'($urandom), pick_value(), pick_value(),
			1'($urandom));
	endtask

	task automatic random_empty();
		send_item(cspmv_pkg::ACT_EMPTY, INDEX_BITS'($urandom), pick_value(), pick_value(),
			1'($urandom));
	endtask

	// One row of nonzeros; loads and empty rows may cut in, and now and then
	// the row is left open so that it runs on into the next one.
	task automatic random_row();
		int  len;
		bit  close;
		len = $urandom_range(1, 8);
		close = ($urandom_range(9) != 0);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(99) < 15) begin
				if ($urandom_range(1) == 0)
					random_load();
				else
					random_empty();
			end
			send_item(cspmv_pkg::ACT_NONZERO, pick_column(), pick_value(), pick_value(),
				close && (k == len - 1));
		end
	endtask

	// A long row of near-extreme products that drives the accumulators into
	// their limits; the columns alternate between the two given entries.
	task automatic clipping_row(input logic signed [VALUE_BITS-1:0] a_re,
			input logic signed [VALUE_BITS-1:0] a_im,
			input logic [INDEX_BITS-1:0] col_a, input logic [INDEX_BITS-1:0] col_b,
			input int len);
		for (int k = 0; k < len; k++)
			send_item(cspmv_pkg::ACT_NONZERO, (k % 2 == 1) ? col_b : col_a, a_re, a_im,
				k == len - 1);
	endtask

	initial begin
		int stop;
		logic [INDEX_BITS-1:0] col_a;
		logic [INDEX_BITS-1:0] col_c;
		arst_n = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		item_if.valid = 1'b0;
		item_if.action = cspmv_pkg::ACT_LOAD;
		item_if.index = '0;
		item_if.value_re = '0;
		item_if.value_im = '0;
		item_if.last_in_row = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: store extremes, single-term rows, rows interrupted by
		// loads and empty rows, last marks on other actions, unknown action.
		send_item(cspmv_pkg::ACT_LOAD, '0, VAL_MAX, VAL_MAX, 1'b0);
		send_item(cspmv_pkg::ACT_LOAD, INDEX_TOP, VAL_MIN, VAL_MIN, 1'b1);
		send_item(cspmv_pkg::ACT_LOAD, INDEX_BITS'(1), '0, '0, 1'b0);
		send_item(cspmv_pkg::ACT_LOAD, INDEX_BITS'(2), VAL_MIN, VAL_MAX, 1'b0);
		send_item(cspmv_pkg::ACT_NONZERO, '0, VAL_MAX, VAL_MAX, 1'b1);
		send_item(cspmv_pkg::ACT_NONZERO, INDEX_TOP, VAL_MIN, VAL_MIN, 1'b0);
		send_item(cspmv_pkg::ACT_NONZERO, INDEX_BITS'(2), VAL_MIN, VAL_MAX, 1'b0);
		send_item(cspmv_pkg::ACT_EMPTY, INDEX_BITS'('h555), VAL_MAX, VAL_MIN, 1'b1);
		send_item(cspmv_pkg::ACT_LOAD, INDEX_BITS'('haaa), '1, VALUE_BITS'(1), 1'b1);
		send_item(cspmv_pkg::ACT_NONZERO, INDEX_BITS'('haaa), VALUE_BITS'(1), '1, 1'b1);
		send_item(ACT_UNUSED, INDEX_TOP, VAL_MAX, VAL_MIN, 1'b1);
		send_item(cspmv_pkg::ACT_EMPTY, '0, '0, '0, 1'b0);
		send_item(cspmv_pkg::ACT_NONZERO, INDEX_BITS'(1), VAL_MAX, VAL_MIN, 1'b1);
		send_item(cspmv_pkg::ACT_NONZERO, INDEX_TOP, VAL_MAX, VAL_MIN, 1'b0);
		send_item(cspmv_pkg::ACT_NONZERO, '0, VAL_MIN, VAL_MAX, 1'b1);
		send_item(cspmv_pkg::ACT_LOAD, '0, VAL_MIN, VAL_MAX, 1'b0);
		send_item(cspmv_pkg::ACT_NONZERO, '0, VAL_MIN, VAL_MIN, 1'b1);

		// Random part in four flow-control phases; two of them also carry a
		// row long enough to hit the accumulator limits.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 59;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 59;
				end
				default: begin
					gap_pct = 10;
					stall_pct = 10;
				end
			endcase
			stop = work_items + PHASE_ITEMS;
			while (work_items < stop) begin
				case ($urandom_range(9))
					0: random_load();
					1: random_empty();
					2: begin
						if ($urandom_range(3) == 0)
							send_item(ACT_UNUSED, INDEX_BITS'($urandom), pick_value(),
								pick_value(), 1'($urandom));
						else
							random_load();
					end
					default: random_row();
				endcase
			end
			if (ph == 1 || ph == 2) begin
				col_a = INDEX_BITS'($urandom);
				col_c = col_a ^ INDEX_BITS'($urandom_range(1, 4095));
				send_item(cspmv_pkg::ACT_LOAD, col_a, VAL_MIN, VAL_MAX, 1'b0);
				send_item(cspmv_pkg::ACT_LOAD, col_c, VAL_MAX, VAL_MAX, 1'b0);
				if (ph == 1)
					// Real part climbs to the top, imaginary part to the bottom.
					clipping_row(VAL_MIN, VAL_MIN, col_a, col_c, 540);
				else
					// Real part falls to the bottom.
					clipping_row(VAL_MAX, VAL_MAX, col_a, col_a, 270);
			end
		end

		item_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Items sent: %0d loads, %0d nonzeros, %0d empty rows, %0d with unknown action.",
			n_loads, n_nonzeros, n_empty, n_ignored);
		$display("Row sums checked: %0d, of which %0d saturated.", rows_checked, rows_saturated);
		if (fail_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
